/* rtl/positional_list_store_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the list store checker
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_STORE_UNIT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define PLS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds during reset.
`define PLS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/pls_pkg.sv */
// ---------------------------------------------------------------------------
// pls_pkg
// Types and codes of the positional list store.
// ---------------------------------------------------------------------------
package pls_pkg;

   localparam int unsigned POS_W   = 5;
   localparam int unsigned COUNT_W = 5;

   typedef enum logic [2:0] {
      MODE_INS_POS   = 3'd0,
      MODE_INS_FRONT = 3'd1,
      MODE_INS_END   = 3'd2,
      MODE_DEL_POS   = 3'd3,
      MODE_DEL_FRONT = 3'd4,
      MODE_DEL_END   = 3'd5,
      MODE_LIST      = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef enum logic {
      S_IDLE,
      S_LIST
   } fsm_state_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic [POS_W-1:0]   position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] value_out;
      logic [COUNT_W-1:0] count_out;
      logic               last;
   } rsp_type;

   // Broadcast to every cell: operation and the value to load.
   typedef struct packed {
      cell_op_type        op;
      logic signed [31:0] value;
   } cell_ctrl_type;

endpackage

/* rtl/pls_cell.sv */
// ---------------------------------------------------------------------------
// pls_cell
// One list slot: holds, loads, or takes its left or right neighbor.
// ---------------------------------------------------------------------------
module pls_cell #(
   parameter int unsigned CAPACITY = 16,
   parameter int unsigned INDEX    = 0,
   localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  pls_pkg::cell_ctrl_type ctrl,
   input  logic [CW-1:0]         idx,
   input  logic [CW-1:0]         count,
   input  logic signed [31:0]    left_data,
   input  logic signed [31:0]    right_data,
   output logic signed [31:0]    data
);
   import pls_pkg::*;

   localparam logic [CW-1:0] MY_IDX   = CW'(INDEX);
   localparam logic [CW-1:0] NEXT_IDX = CW'(INDEX + 1);

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            // open a gap at idx: cells above it take their left neighbor
            if (idx == MY_IDX) begin
               data_in = ctrl.value;
            end else if (idx < MY_IDX && MY_IDX <= count) begin
               data_in = left_data;
            end
         end
         CELL_DELETE: begin
            if (idx <= MY_IDX && NEXT_IDX < count) begin
               data_in = right_data;
            end
         end
         CELL_ROTATE: begin
            // the tail slot takes the old head
            if (NEXT_IDX < count) begin
               data_in = right_data;
            end else if (NEXT_IDX == count) begin
               data_in = ctrl.value;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* rtl/positional_list_store_unit.sv */
// ---------------------------------------------------------------------------
// positional_list_store_unit
// Bounded ordered list of signed 32-bit values in a chain of slot cells.
// ---------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready carry one request (mode, position, value).
//   rsp_valid/rsp_ready carry the results; every request gives one result,
//   except list all on a non-empty list, which gives one result per element
//   in order, with last set on the final one.
//   Insert and delete requests shift the cell chain in the accept cycle and
//   their result is visible the next cycle; one request per cycle while
//   the receiver keeps rsp_ready high.
//   List all first enters its stream state and then streams one element per
//   cycle while the receiver keeps rsp_ready high; each step rotates the
//   chain by one slot and the order is back in place after the final
//   element. req_ready stays low while the stream runs.
//   When the receiver stalls, the result register holds its value and no
//   new request is taken until it frees.
//   Reset empties the list and drops any pending result; slot contents are
//   not cleared, since only slots below the count are ever read.
// ---------------------------------------------------------------------------
module positional_list_store_unit #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pls_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pls_pkg::rsp_type rsp_data
);
   import pls_pkg::*;

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned IW = $clog2(CAPACITY);
   localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

   fsm_state_type    state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    list_idx_ff, list_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   cell_ctrl_type      ctrl;
   logic [CW-1:0]      cell_idx;
   logic signed [31:0] cell_data [CAPACITY];

   logic          out_free;
   logic          req_fire;
   logic          load_rsp;
   logic          is_empty;
   logic          is_full;
   logic [PW-1:0] pos_ext;
   logic [PW-1:0] cnt_ext;
   logic          list_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CW'(CAPACITY));
   assign pos_ext   = PW'(req_data.position);
   assign cnt_ext   = PW'(count_ff);
   assign list_last = ((list_idx_ff + CW'(1)) == count_ff);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      list_idx_in = list_idx_ff;
      ctrl.op     = CELL_HOLD;
      ctrl.value  = req_data.value;
      cell_idx    = '0;
      load_rsp    = 1'b0;
      rsp_data_in = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               load_rsp              = 1'b1;
               rsp_data_in.status    = ST_OK;
               rsp_data_in.value_out = '0;
               rsp_data_in.last      = 1'b1;
               case (req_data.mode)
                  MODE_INS_POS: begin
                     if (is_empty) begin
                        rsp_data_in.status = ST_EMPTY;
                     end else if (is_full) begin
                        rsp_data_in.status = ST_FULL;
                     end else if (req_data.position == '0) begin
                        rsp_data_in.status = ST_RANGE;
                     end else begin
                        // past the end appends
                        cell_idx = (pos_ext > cnt_ext) ? count_ff
                                                       : CW'(pos_ext - PW'(1));
                        ctrl.op  = CELL_INSERT;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  MODE_INS_FRONT, MODE_INS_END: begin
                     if (is_full) begin
                        rsp_data_in.status = ST_FULL;
                     end else begin
                        cell_idx = (req_data.mode == MODE_INS_FRONT) ? '0 : count_ff;
                        ctrl.op  = CELL_INSERT;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  MODE_DEL_POS: begin
                     if (is_empty) begin
                        rsp_data_in.status = ST_EMPTY;
                     end else if (req_data.position == '0 || pos_ext > cnt_ext) begin
                        rsp_data_in.status = ST_RANGE;
                     end else begin
                        cell_idx              = CW'(pos_ext - PW'(1));
                        ctrl.op               = CELL_DELETE;
                        count_in              = count_ff - CW'(1);
                        rsp_data_in.value_out = cell_data[cell_idx[IW-1:0]];
                     end
                  end
                  MODE_DEL_FRONT, MODE_DEL_END: begin
                     if (is_empty) begin
                        rsp_data_in.status = ST_EMPTY;
                     end else begin
                        cell_idx = (req_data.mode == MODE_DEL_FRONT) ? '0
                                                                     : count_ff - CW'(1);
                        ctrl.op               = CELL_DELETE;
                        count_in              = count_ff - CW'(1);
                        rsp_data_in.value_out = cell_data[cell_idx[IW-1:0]];
                     end
                  end
                  MODE_LIST: begin
                     if (is_empty) begin
                        rsp_data_in.status = ST_EMPTY;
                     end else begin
                        // no result yet; stream from the next cycle
                        load_rsp    = 1'b0;
                        list_idx_in = '0;
                        state_in    = S_LIST;
                     end
                  end
                  default: begin
                     rsp_data_in.status = ST_OK;
                  end
               endcase
               rsp_data_in.count_out = COUNT_W'(count_in);
            end
         end
         S_LIST: begin
            if (out_free) begin
               // emit the head and rotate it to the tail
               load_rsp              = 1'b1;
               ctrl.op               = CELL_ROTATE;
               ctrl.value            = cell_data[0];
               rsp_data_in.status    = ST_OK;
               rsp_data_in.value_out = cell_data[0];
               rsp_data_in.count_out = COUNT_W'(count_ff);
               rsp_data_in.last      = list_last;
               list_idx_in           = list_idx_ff + CW'(1);
               if (list_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         list_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         list_idx_ff  <= list_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] left_data;
      logic signed [31:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end

      pls_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .idx        (cell_idx),
         .count      (count_ff),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/pls_checker.sv */
// ---------------------------------------------------------------------------
// pls_checker
// Port-level checks of the positional list store.
// ---------------------------------------------------------------------------
`include "positional_list_store_unit_macros.svh"

module pls_checker #(
   parameter int unsigned CAPACITY = 16
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pls_pkg::rsp_type rsp_data
);
   import pls_pkg::*;

   `PLS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result changed while stalled")

   `PLS_ASSERT(a_error_is_last, clock, reset, rsp_valid && rsp_data.status != ST_OK |-> rsp_data.last, "error result not marked last")

   `PLS_ASSERT(a_empty_count, clock, reset, rsp_valid && rsp_data.status == ST_EMPTY |-> rsp_data.count_out == '0, "empty status with nonzero count")

   `PLS_ASSERT(a_stream_blocks, clock, reset, rsp_valid && !rsp_data.last |-> !req_ready, "request taken during list stream")

   `PLS_ASSERT_ALWAYS(a_count_bound, clock, reset || !rsp_valid || 32'(rsp_data.count_out) <= CAPACITY, "count above capacity")

endmodule

bind positional_list_store_unit pls_checker #(.CAPACITY(CAPACITY)) u_pls_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
